>>> hw/rtl/deq_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deque package
// Shared types and constants of the bounded double-ended queue.
// ----------------------------------------------------------------------------
package deq_pkg;

  localparam int DEPTH_DEF  = 64;
  localparam int GROUP_SIZE = 8;
  localparam int ID_W       = 32;
  localparam int CMD_W      = 3;
  localparam int STATUS_W   = 2;
  localparam int COUNT_W    = 7;

  typedef enum logic [CMD_W-1:0] {
    CMD_PUSH_FRONT = 3'd0,
    CMD_PUSH_BACK  = 3'd1,
    CMD_POP_FRONT  = 3'd2,
    CMD_POP_BACK   = 3'd3,
    CMD_CLEAR      = 3'd4
  } cmd_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } status_t;

  typedef struct packed {
    logic clear;
    logic shift_right;
    logic push_back;
    logic shift_left;
    logic drop_tail;
  } cell_ctl_t;

endpackage

`default_nettype wire

>>> hw/rtl/deq_if.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deque channel interfaces
// Valid/ready channels for commands and results.
// ----------------------------------------------------------------------------
interface deq_in_if;
  logic                            valid;
  logic                            ready;
  logic [deq_pkg::CMD_W-1:0]       cmd;
  logic signed [deq_pkg::ID_W-1:0] order_id;

  modport source (output valid, output cmd, output order_id, input ready);
  modport sink (input valid, input cmd, input order_id, output ready);
endinterface

interface deq_out_if;
  logic                             valid;
  logic                             ready;
  logic [deq_pkg::STATUS_W-1:0]     status;
  logic                             popped_valid;
  logic signed [deq_pkg::ID_W-1:0]  popped_id;
  logic [deq_pkg::COUNT_W-1:0]      entry_count;

  modport source (output valid, output status, output popped_valid, output popped_id,
                  output entry_count, input ready);
  modport sink (input valid, input status, input popped_valid, input popped_id,
                input entry_count, output ready);
endinterface

`default_nettype wire

>>> hw/rtl/bounded_deque_top.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Bounded deque top level
// Double-ended queue of 32-bit identifiers held in a row of shifting cells.
// ----------------------------------------------------------------------------
// Commands arrive on in_chan and each one produces exactly one result word on
// out_chan carrying the status, the popped identifier and the entry count.
// The entries sit packed from cell 0 (front) upward; a push at the front or a
// pop at the front shifts the whole row by one cell, while a back push or pop
// touches only the cell at the boundary of the occupied run.
// A command is applied to the cells as it is accepted, so one command per
// cycle is sustained while the receiver keeps up. Each result passes through
// a holding stage and then the output register; the back entry is gathered
// through an OR tree whose groups of eight cells are registered in that stage.
// When the receiver stalls, the output register holds its word, the holding
// stage keeps one more result, and in_chan.ready drops until room frees up.
// A synchronous active-low reset empties the queue and drops both stages;
// no clearing pass is needed since empty cells are marked by their own flags.
// ----------------------------------------------------------------------------
module bounded_deque_top #(
  parameter int DEPTH = deq_pkg::DEPTH_DEF
) (
  input  wire logic  clk,
  input  wire logic  rst_n,
  deq_in_if.sink     in_chan,
  deq_out_if.source  out_chan
);

  localparam int CNT_W  = $clog2(DEPTH + 1);
  localparam int NGROUP = (DEPTH + deq_pkg::GROUP_SIZE - 1) / deq_pkg::GROUP_SIZE;
  localparam int NPAD   = NGROUP * deq_pkg::GROUP_SIZE;
  localparam int ID_W   = deq_pkg::ID_W;

  logic                 fire;
  logic                 step;
  deq_pkg::cell_ctl_t   ctl;
  logic [CNT_W-1:0]     count_r;
  logic [CNT_W-1:0]     count_nxt;
  deq_pkg::status_t     status_now;
  logic                 pop_now;
  logic                 pop_front_now;
  logic                 is_full;
  logic                 is_empty;

  logic [ID_W-1:0]      cell_data [DEPTH];
  logic [DEPTH-1:0]     cell_full;
  logic [ID_W-1:0]      tail_word [NPAD];
  logic [ID_W-1:0]      group_or  [NGROUP];

  logic                 pend_valid_r;
  deq_pkg::status_t     pend_status_r;
  logic                 pend_pop_r;
  logic                 pend_front_r;
  logic [ID_W-1:0]      pend_head_r;
  logic [ID_W-1:0]      pend_group_r [NGROUP];
  logic [CNT_W-1:0]     pend_count_r;
  logic [ID_W-1:0]      pend_tail;

  logic                 out_valid_r;
  logic [deq_pkg::STATUS_W-1:0] out_status_r;
  logic                 out_pop_r;
  logic [ID_W-1:0]      out_id_r;
  logic [deq_pkg::COUNT_W-1:0]  out_count_r;
  logic                 out_load;

  assign out_load      = pend_valid_r && (!out_valid_r || out_chan.ready);
  assign in_chan.ready = !pend_valid_r || out_load;
  assign fire          = in_chan.valid && in_chan.ready;
  assign is_full       = (count_r == CNT_W'(DEPTH));
  assign is_empty      = (count_r == '0);

  always_comb begin
    ctl           = '0;
    count_nxt     = count_r;
    status_now    = deq_pkg::ST_OK;
    pop_now       = 1'b0;
    pop_front_now = 1'b0;
    unique case (in_chan.cmd)
      deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
        if (is_full) begin
          status_now = deq_pkg::ST_FULL;
        end else begin
          ctl.shift_right = (in_chan.cmd == deq_pkg::CMD_PUSH_FRONT);
          ctl.push_back   = (in_chan.cmd == deq_pkg::CMD_PUSH_BACK);
          count_nxt       = count_r + 1'b1;
        end
      end
      deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
        if (is_empty) begin
          status_now = deq_pkg::ST_EMPTY;
        end else begin
          ctl.shift_left = (in_chan.cmd == deq_pkg::CMD_POP_FRONT);
          ctl.drop_tail  = (in_chan.cmd == deq_pkg::CMD_POP_BACK);
          pop_now        = 1'b1;
          pop_front_now  = (in_chan.cmd == deq_pkg::CMD_POP_FRONT);
          count_nxt      = count_r - 1'b1;
        end
      end
      deq_pkg::CMD_CLEAR: begin
        ctl.clear = 1'b1;
        count_nxt = '0;
      end
      default: begin
      end
    endcase
  end

  assign step = fire;

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [ID_W-1:0] l_data;
    logic            l_full;
    logic [ID_W-1:0] r_data;
    logic            r_full;

    if (i == 0) begin : g_first
      assign l_data = in_chan.order_id;
      assign l_full = 1'b1;
    end else begin : g_mid_l
      assign l_data = cell_data[i-1];
      assign l_full = cell_full[i-1];
    end

    if (i == DEPTH - 1) begin : g_last
      assign r_data = '0;
      assign r_full = 1'b0;
    end else begin : g_mid_r
      assign r_data = cell_data[i+1];
      assign r_full = cell_full[i+1];
    end

    deq_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .step       (step),
      .ctl        (ctl),
      .new_id     (in_chan.order_id),
      .left_data  (l_data),
      .left_full  (l_full),
      .right_data (r_data),
      .right_full (r_full),
      .data       (cell_data[i]),
      .full       (cell_full[i]),
      .tail_word  (tail_word[i])
    );
  end

  for (genvar p = DEPTH; p < NPAD; p++) begin : g_pad
    assign tail_word[p] = '0;
  end

  always_comb begin
    for (int g = 0; g < NGROUP; g++) begin
      group_or[g] = '0;
      for (int k = 0; k < deq_pkg::GROUP_SIZE; k++) begin
        group_or[g] = group_or[g] | tail_word[g * deq_pkg::GROUP_SIZE + k];
      end
    end
  end

  always_comb begin
    pend_tail = '0;
    for (int g = 0; g < NGROUP; g++) begin
      pend_tail = pend_tail | pend_group_r[g];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      count_r <= '0;
    end else if (fire) begin
      count_r <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pend_valid_r <= 1'b0;
    end else if (fire) begin
      pend_valid_r <= 1'b1;
    end else if (out_load) begin
      pend_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (fire) begin
      pend_status_r <= status_now;
      pend_pop_r    <= pop_now;
      pend_front_r  <= pop_front_now;
      pend_head_r   <= cell_data[0];
      pend_count_r  <= count_nxt;
      pend_group_r  <= group_or;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_load) begin
      out_valid_r <= 1'b1;
    end else if (out_chan.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_status_r <= pend_status_r;
      out_pop_r    <= pend_pop_r;
      out_id_r     <= !pend_pop_r ? '0 : (pend_front_r ? pend_head_r : pend_tail);
      out_count_r  <= deq_pkg::COUNT_W'(pend_count_r);
    end
  end

  assign out_chan.valid        = out_valid_r;
  assign out_chan.status       = out_status_r;
  assign out_chan.popped_valid = out_pop_r;
  assign out_chan.popped_id    = out_id_r;
  assign out_chan.entry_count  = out_count_r;

  a_count_bound : assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(DEPTH))
    else $error("entry count above depth");

  a_cells_match_count : assert property (@(posedge clk) disable iff (!rst_n)
    $countones(cell_full) == int'(count_r))
    else $error("occupied cells disagree with entry count");

  a_pend_held : assert property (@(posedge clk) disable iff (!rst_n)
    pend_valid_r && !out_load |=> pend_valid_r)
    else $error("pending result lost while output stalled");

  a_pop_status : assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && out_pop_r |-> out_status_r == deq_pkg::ST_OK)
    else $error("popped word with non-ok status");

endmodule

`default_nettype wire

>>> hw/rtl/deq_cell.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// Deque cell
// One queue slot; shifts toward either neighbor or takes a new word.
// ----------------------------------------------------------------------------
module deq_cell (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire logic                       step,
  input  wire deq_pkg::cell_ctl_t         ctl,
  input  wire logic [deq_pkg::ID_W-1:0]   new_id,
  input  wire logic [deq_pkg::ID_W-1:0]   left_data,
  input  wire logic                       left_full,
  input  wire logic [deq_pkg::ID_W-1:0]   right_data,
  input  wire logic                       right_full,
  output logic [deq_pkg::ID_W-1:0]        data,
  output logic                            full,
  output logic [deq_pkg::ID_W-1:0]        tail_word
);

  logic [deq_pkg::ID_W-1:0] data_r;
  logic [deq_pkg::ID_W-1:0] data_nxt;
  logic                     full_r;
  logic                     full_nxt;
  logic                     is_tail;

  assign is_tail = full_r && !right_full;

  always_comb begin
    data_nxt = data_r;
    full_nxt = full_r;
    if (ctl.clear) begin
      full_nxt = 1'b0;
    end else if (ctl.shift_right) begin
      data_nxt = left_data;
      full_nxt = left_full;
    end else if (ctl.push_back) begin
      if (!full_r && left_full) begin
        data_nxt = new_id;
        full_nxt = 1'b1;
      end
    end else if (ctl.shift_left) begin
      data_nxt = right_data;
      full_nxt = right_full;
    end else if (ctl.drop_tail) begin
      if (is_tail) begin
        full_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (step) begin
      data_r <= data_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      full_r <= 1'b0;
    end else if (step) begin
      full_r <= full_nxt;
    end
  end

  assign data      = data_r;
  assign full      = full_r;
  assign tail_word = is_tail ? data_r : '0;

endmodule

`default_nettype wire

>>> bench/tb_bounded_deque_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// Bounded deque testbench
// Sends directed and random command words into the deque. A behavioral ring
// model predicts every result word, and each field is checked as the word
// leaves the block. Backpressure varies from phase to phase, and one phase
// holds off the receiver until the block stalls its input.
// ----------------------------------------------------------------------------
module tb_bounded_deque_top;

  localparam int DEPTH            = deq_pkg::DEPTH_DEF;
  localparam int CMD_W            = deq_pkg::CMD_W;
  localparam int ID_W             = deq_pkg::ID_W;
  localparam int COUNT_W          = deq_pkg::COUNT_W;
  localparam int RANDOM_PER_PHASE = 300;
  localparam int STALL_LIMIT      = 2000;
  localparam int HOLD_CYCLES      = 60;
  localparam int TAIL_CYCLES      = 8;

  localparam logic [CMD_W-1:0] CMD_RSVD_5 = 3'd5;
  localparam logic [CMD_W-1:0] CMD_RSVD_6 = 3'd6;
  localparam logic [CMD_W-1:0] CMD_RSVD_7 = 3'd7;

  typedef struct {
    deq_pkg::status_t         status;
    logic                     popped_valid;
    logic signed [ID_W-1:0]   popped_id;
    logic [COUNT_W-1:0]       entry_count;
  } deq_result_t;

  logic clk;
  logic rst_n;

  deq_in_if  in_chan();
  deq_out_if out_chan();

  bounded_deque_top #(.DEPTH(DEPTH)) dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_chan  (in_chan),
    .out_chan (out_chan)
  );

  logic [ID_W-1:0] ring_mem [DEPTH];
  int              ring_front;
  int              ring_count;
  deq_result_t     pending_results [$];

  int unsigned err_count     = 0;
  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned hold_requests = 0;
  int unsigned stall_cycles  = 0;

  initial begin
    clk = 1'b0;
    forever #1 clk = ~clk;
  end

  function automatic deq_result_t deque_apply(input logic [CMD_W-1:0] cmd,
                                              input logic [ID_W-1:0] id);
    deq_result_t r;
    int          pos;
    r.status       = deq_pkg::ST_OK;
    r.popped_valid = 1'b0;
    r.popped_id    = '0;
    case (cmd)
      deq_pkg::CMD_PUSH_FRONT, deq_pkg::CMD_PUSH_BACK: begin
        if (ring_count >= DEPTH) begin
          r.status = deq_pkg::ST_FULL;
        end else begin
          if (cmd == deq_pkg::CMD_PUSH_FRONT) begin
            ring_front = (ring_front + DEPTH - 1) % DEPTH;
            pos        = ring_front;
          end else begin
            pos = (ring_front + ring_count) % DEPTH;
          end
          ring_mem[pos] = id;
          ring_count++;
        end
      end
      deq_pkg::CMD_POP_FRONT, deq_pkg::CMD_POP_BACK: begin
        if (ring_count == 0) begin
          r.status = deq_pkg::ST_EMPTY;
        end else begin
          if (cmd == deq_pkg::CMD_POP_FRONT) begin
            pos        = ring_front;
            ring_front = (ring_front + 1) % DEPTH;
          end else begin
            pos = (ring_front + ring_count - 1) % DEPTH;
          end
          r.popped_id    = ring_mem[pos];
          r.popped_valid = 1'b1;
          ring_count--;
        end
      end
      deq_pkg::CMD_CLEAR: begin
        ring_front = 0;
        ring_count = 0;
      end
      default: begin
      end
    endcase
    r.entry_count = ring_count[COUNT_W-1:0];
    return r;
  endfunction

  function automatic logic [CMD_W-1:0] pick_cmd(input int unsigned push_pct);
    int unsigned roll;
    roll = $urandom_range(999);
    if (roll < 6) return deq_pkg::CMD_CLEAR;
    if (roll < 26) return CMD_W'(CMD_RSVD_5 + $urandom_range(2));
    if ($urandom_range(99) < push_pct) begin
      return $urandom_range(1) ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT;
    end
    return $urandom_range(1) ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT;
  endfunction

  function automatic logic [ID_W-1:0] pick_id();
    case ($urandom_range(15))
      0: return 32'h8000_0000;
      1: return 32'h7FFF_FFFF;
      2: return '0;
      3: return '1;
      default: return $urandom();
    endcase
  endfunction

  task automatic send_word(input logic [CMD_W-1:0] cmd, input logic [ID_W-1:0] id);
    while ($urandom_range(99) < send_idle_pct) begin
      in_chan.valid <= 1'b0;
      @(posedge clk);
    end
    in_chan.valid    <= 1'b1;
    in_chan.cmd      <= cmd;
    in_chan.order_id <= id;
    @(posedge clk);
    while (!in_chan.ready) @(posedge clk);
    pending_results.push_back(deque_apply(cmd, id));
  endtask

  task automatic wait_drain();
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic test_directed();
    send_word(deq_pkg::CMD_POP_FRONT, 32'h1234_5678);
    send_word(deq_pkg::CMD_POP_BACK, '1);
    send_word(deq_pkg::CMD_PUSH_FRONT, 32'h8000_0000);
    send_word(deq_pkg::CMD_PUSH_BACK, 32'h7FFF_FFFF);
    send_word(deq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFF);
    send_word(deq_pkg::CMD_PUSH_BACK, 32'h0000_0000);
    send_word(CMD_RSVD_5, 32'hDEAD_BEEF);
    send_word(CMD_RSVD_6, 32'h0F0F_0F0F);
    send_word(CMD_RSVD_7, 32'hF0F0_F0F0);
    send_word(deq_pkg::CMD_POP_BACK, '0);
    send_word(deq_pkg::CMD_POP_FRONT, '0);
    send_word(deq_pkg::CMD_PUSH_BACK, 32'h5555_5555);
    send_word(deq_pkg::CMD_PUSH_FRONT, 32'hAAAA_AAAA);
    send_word(deq_pkg::CMD_CLEAR, 32'h0000_0001);
    send_word(deq_pkg::CMD_POP_FRONT, '0);
    send_word(deq_pkg::CMD_POP_BACK, '0);
    send_word(deq_pkg::CMD_CLEAR, '0);
    send_word(deq_pkg::CMD_PUSH_BACK, 32'h0000_0001);
    send_word(deq_pkg::CMD_POP_FRONT, '0);
    send_word(deq_pkg::CMD_PUSH_FRONT, 32'hFFFF_FFFE);
    send_word(deq_pkg::CMD_POP_BACK, '0);
    wait_drain();
  endtask

  // The receiver holds off at the start, so the pushes back up into the block
  // while the ring itself runs up to full and then back down to empty.
  task automatic test_fill_and_stall();
    int i;
    send_idle_pct = 0;
    recv_idle_pct = 0;
    hold_requests++;
    for (i = 0; i < DEPTH + 2; i++) begin
      send_word(i[0] ? deq_pkg::CMD_PUSH_BACK : deq_pkg::CMD_PUSH_FRONT, $urandom());
    end
    for (i = 0; i < DEPTH + 2; i++) begin
      send_word(i[1] ? deq_pkg::CMD_POP_BACK : deq_pkg::CMD_POP_FRONT, $urandom());
    end
    wait_drain();
  endtask

  task automatic run_random_phase(input int unsigned snd_pct, input int unsigned rcv_pct);
    int n;
    int run_len;
    int unsigned push_pct;
    send_idle_pct = snd_pct;
    recv_idle_pct = rcv_pct;
    n = 0;
    while (n < RANDOM_PER_PHASE) begin
      run_len = $urandom_range(1, 64);
      case ($urandom_range(2))
        0: push_pct = 90;
        1: push_pct = 15;
        default: push_pct = 50;
      endcase
      repeat (run_len) begin
        send_word(pick_cmd(push_pct), pick_id());
        n++;
      end
    end
    wait_drain();
  endtask

  initial begin : result_sink
    int unsigned seen_holds;
    int unsigned hold_left;
    deq_result_t exp;
    seen_holds     = 0;
    hold_left      = 0;
    out_chan.ready = 1'b0;
    forever begin
      @(posedge clk);
      if (rst_n && out_chan.valid && out_chan.ready) begin
        if (pending_results.size() == 0) begin
          err_count++;
          $display("%0t: unexpected result word, status %0d, id %0h, count %0d", $time,
                   out_chan.status, out_chan.popped_id, out_chan.entry_count);
        end else begin
          exp = pending_results.pop_front();
          if (out_chan.status !== exp.status) begin
            err_count++;
            $display("%0t: status mismatch, expected %0d, got %0d", $time, exp.status,
                     out_chan.status);
          end
          if (out_chan.popped_valid !== exp.popped_valid) begin
            err_count++;
            $display("%0t: popped_valid mismatch, expected %0d, got %0d", $time,
                     exp.popped_valid, out_chan.popped_valid);
          end
          if (out_chan.popped_id !== exp.popped_id) begin
            err_count++;
            $display("%0t: popped_id mismatch, expected %h, got %h", $time, exp.popped_id,
                     out_chan.popped_id);
          end
          if (out_chan.entry_count !== exp.entry_count) begin
            err_count++;
            $display("%0t: entry_count mismatch, expected %0d, got %0d", $time,
                     exp.entry_count, out_chan.entry_count);
          end
        end
      end
      if (hold_requests != seen_holds) begin
        seen_holds = hold_requests;
        hold_left  = HOLD_CYCLES;
      end
      if (hold_left != 0) begin
        hold_left--;
        out_chan.ready <= 1'b0;
      end else begin
        out_chan.ready <= ($urandom_range(99) >= recv_idle_pct);
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n) begin
      stall_cycles <= 0;
    end else if ((in_chan.valid && in_chan.ready) || (out_chan.valid && out_chan.ready)) begin
      stall_cycles <= 0;
    end else if (stall_cycles >= STALL_LIMIT) begin
      $display("RESULT: ERROR");
      $finish;
    end else begin
      stall_cycles <= stall_cycles + 1;
    end
  end

  initial begin
    in_chan.valid    = 1'b0;
    in_chan.cmd      = deq_pkg::CMD_CLEAR;
    in_chan.order_id = '0;
    rst_n            = 1'b0;
    ring_front       = 0;
    ring_count       = 0;
    foreach (ring_mem[i]) ring_mem[i] = '0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    test_directed();
    test_fill_and_stall();
    run_random_phase(12, 81);
    run_random_phase(81, 12);
    run_random_phase(0, 0);
    in_chan.valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (TAIL_CYCLES) @(posedge clk);
    if (err_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
